[sv/pru_pkg.sv]
// shared types, codes and address helpers for the picture unit register port
package pru_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [1:0] CFG_MIRROR = 2'd0;
  localparam logic [1:0] CFG_ROM    = 2'd1;
  localparam logic [1:0] CFG_FRAME  = 2'd2;

  localparam int SPRITE_BYTES  = 256;
  localparam int PALETTE_BYTES = 32;
  localparam int PATTERN_BYTES = 8192;
  localparam int SPR_AW  = 8;
  localparam int PAL_AW  = 5;
  localparam int PAT_AW  = 13;
  localparam int NT_AW_MAX = 12;

  localparam logic [13:0] PALETTE_BASE   = 14'h3F00;
  localparam logic [13:0] NAMETABLE_BASE = 14'h2000;
  localparam logic [7:0]  HUD_CTRL_MASK  = 8'h38;
  localparam logic [15:0] RESET_FRAME    = 16'd29781;

  // what the output stage does with the memory data of an item
  typedef enum logic [2:0] {
    RK_NONE     = 3'd0,
    RK_STATUS   = 3'd1,
    RK_SPRITE   = 3'd2,
    RK_PALETTE  = 3'd3,
    RK_VRAM_NT  = 3'd4,
    RK_VRAM_PAT = 3'd5,
    RK_ADDR_CLR = 3'd6
  } rkind_t;

  typedef struct packed {
    logic                 spr_we;
    logic [SPR_AW-1:0]    spr_addr;
    logic                 pal_we;
    logic [PAL_AW-1:0]    pal_addr;
    logic                 nt_we;
    logic [NT_AW_MAX-1:0] nt_addr;
    logic                 pat_we;
    logic [PAT_AW-1:0]    pat_addr;
    logic [7:0]           wdata;
  } mem_req_t;

  typedef struct packed {
    rkind_t     kind;
    logic [7:0] value;
    logic       nmi;
    logic       split;
    logic [7:0] hud_x;
    logic [7:0] hud_y;
    logic [7:0] hud_ctrl;
  } s1_info_t;

  // entries 0x10/0x14/0x18/0x1c alias the background ones
  function automatic logic [PAL_AW-1:0] pal_index(input logic [13:0] a);
    logic [PAL_AW-1:0] i;
    i = a[PAL_AW-1:0];
    if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
    return i;
  endfunction

  function automatic logic [NT_AW_MAX-1:0] nt_index(input logic [2:0] mode,
                                                    input logic [13:0] a);
    logic page;
    case (mode)
      3'd0:    page = 1'b0;
      3'd1:    page = 1'b1;
      3'd3:    page = a[11];
      default: page = a[10];
    endcase
    return {1'b0, page, a[9:0]};
  endfunction

endpackage

[sv/pru_mem.sv]
// sprite, palette, nametable and pattern memories with the clearing pass after reset
module pru_mem #(
  parameter int NAMETABLE_BYTES = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  pru_pkg::mem_req_t req,
  output logic             clear_busy,
  output logic [7:0]       spr_q,
  output logic [7:0]       pal_q,
  output logic [7:0]       nt_q,
  output logic [7:0]       pat_q
);

  localparam int NT_AW = $clog2(NAMETABLE_BYTES);

  logic [7:0] spr_ram [pru_pkg::SPRITE_BYTES];
  logic [7:0] pal_ram [pru_pkg::PALETTE_BYTES];
  logic [7:0] nt_ram  [NAMETABLE_BYTES];
  logic [7:0] pat_ram [pru_pkg::PATTERN_BYTES];

  logic [pru_pkg::PAT_AW-1:0] clr_cnt;
  logic [NT_AW-1:0]           nt_a;

  assign nt_a = req.nt_addr[NT_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_cnt    <= '0;
    end else if (clear_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) clear_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      spr_ram[clr_cnt[pru_pkg::SPR_AW-1:0]] <= '0;
      pal_ram[clr_cnt[pru_pkg::PAL_AW-1:0]] <= '0;
      nt_ram[clr_cnt[NT_AW-1:0]]            <= '0;
      pat_ram[clr_cnt]                      <= '0;
    end else begin
      if (req.spr_we) spr_ram[req.spr_addr] <= req.wdata;
      if (req.pal_we) pal_ram[req.pal_addr] <= req.wdata;
      if (req.nt_we)  nt_ram[nt_a]          <= req.wdata;
      if (req.pat_we) pat_ram[req.pat_addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      spr_q <= spr_ram[req.spr_addr];
      pal_q <= pal_ram[req.pal_addr];
      nt_q  <= nt_ram[nt_a];
      pat_q <= pat_ram[req.pat_addr];
    end
  end

endmodule

[sv/pru_regs.sv]
// register file, command decode and memory request generation
module pru_regs #(
  parameter int HIT_POLLS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [1:0]        cmd,
  input  logic [2:0]        reg_index,
  input  logic [7:0]        write_data,
  input  logic [7:0]        tick_cycles,
  input  logic [2:0]        mirror_mode,
  input  logic              pattern_is_rom,
  input  logic [15:0]       frame_cycles,
  output pru_pkg::mem_req_t req,
  output pru_pkg::s1_info_t info
);

  logic [7:0]  control_reg, mask_reg, status_reg, sprite_addr, scroll_x, scroll_y;
  logic [15:0] vram_addr;
  logic        addr_toggle, scroll_toggle, split_flag;
  logic [1:0]  poll_count;
  logic [7:0]  hud_x_reg, hud_y_reg, hud_ctrl_reg;
  logic [16:0] cycle_total;

  logic [7:0]  control_next, mask_next, status_next, sprite_addr_next;
  logic [7:0]  scroll_x_next, scroll_y_next;
  logic [15:0] vram_addr_next;
  logic        addr_toggle_next, scroll_toggle_next, split_next;
  logic [1:0]  poll_next, poll_inc;
  logic [7:0]  hud_x_next, hud_y_next, hud_ctrl_next;
  logic [16:0] cycle_next, cycle_sum;
  logic [13:0] a;
  logic [15:0] vram_step;

  always_comb begin
    control_next       = control_reg;
    mask_next          = mask_reg;
    status_next        = status_reg;
    sprite_addr_next   = sprite_addr;
    scroll_x_next      = scroll_x;
    scroll_y_next      = scroll_y;
    vram_addr_next     = vram_addr;
    addr_toggle_next   = addr_toggle;
    scroll_toggle_next = scroll_toggle;
    split_next         = split_flag;
    poll_next          = poll_count;
    hud_x_next         = hud_x_reg;
    hud_y_next         = hud_y_reg;
    hud_ctrl_next      = hud_ctrl_reg;
    cycle_next         = cycle_total;
    a                  = vram_addr[13:0];
    vram_step          = vram_addr + (control_reg[2] ? 16'd32 : 16'd1);
    poll_inc           = poll_count + 2'd1;
    cycle_sum          = cycle_total + {9'd0, (tick_cycles == 8'd0) ? 8'd1 : tick_cycles};

    req          = '0;
    req.spr_addr = sprite_addr;
    req.pal_addr = pru_pkg::pal_index(a);
    req.nt_addr  = pru_pkg::nt_index(mirror_mode, a);
    req.pat_addr = a[pru_pkg::PAT_AW-1:0];
    req.wdata    = write_data;

    info       = '0;
    info.kind  = pru_pkg::RK_NONE;
    info.value = status_reg;

    case (cmd)
      pru_pkg::CMD_READ: begin
        case (reg_index)
          pru_pkg::REG_STATUS: begin
            info.kind          = pru_pkg::RK_STATUS;
            status_next        = status_reg & 8'h7F;
            scroll_toggle_next = 1'b0;
            addr_toggle_next   = 1'b0;
            if (status_reg[6]) begin
              status_next[6] = 1'b0;
              poll_next      = '0;
            end else if (poll_inc >= 2'(HIT_POLLS)) begin
              hud_x_next     = scroll_x;
              hud_y_next     = scroll_y;
              hud_ctrl_next  = control_reg & pru_pkg::HUD_CTRL_MASK;
              split_next     = 1'b1;
              status_next[6] = 1'b1;
              poll_next      = '0;
            end else begin
              poll_next = poll_inc;
            end
          end
          pru_pkg::REG_OAM_DATA: info.kind = pru_pkg::RK_SPRITE;
          pru_pkg::REG_DATA: begin
            vram_addr_next = vram_step;
            if (a >= pru_pkg::PALETTE_BASE)        info.kind = pru_pkg::RK_PALETTE;
            else if (a >= pru_pkg::NAMETABLE_BASE) info.kind = pru_pkg::RK_VRAM_NT;
            else                                   info.kind = pru_pkg::RK_VRAM_PAT;
          end
          default: ;
        endcase
      end
      pru_pkg::CMD_WRITE: begin
        poll_next = '0;
        case (reg_index)
          pru_pkg::REG_CTRL:     control_next = write_data;
          pru_pkg::REG_MASK:     mask_next = write_data;
          pru_pkg::REG_OAM_ADDR: sprite_addr_next = write_data;
          pru_pkg::REG_OAM_DATA: begin
            req.spr_we       = 1'b1;
            sprite_addr_next = sprite_addr + 8'd1;
          end
          pru_pkg::REG_SCROLL: begin
            if (!scroll_toggle) scroll_x_next = write_data;
            else                scroll_y_next = write_data;
            scroll_toggle_next = !scroll_toggle;
          end
          pru_pkg::REG_ADDR: begin
            if (!addr_toggle) vram_addr_next = {write_data, 8'd0};
            else              vram_addr_next = vram_addr | {8'd0, write_data};
            addr_toggle_next = !addr_toggle;
            info.kind        = pru_pkg::RK_ADDR_CLR;
          end
          pru_pkg::REG_DATA: begin
            if (a >= pru_pkg::PALETTE_BASE)        req.pal_we = 1'b1;
            else if (a >= pru_pkg::NAMETABLE_BASE) req.nt_we = 1'b1;
            else                                   req.pat_we = !pattern_is_rom;
            vram_addr_next = vram_step;
          end
          default: ;
        endcase
      end
      pru_pkg::CMD_TICK: begin
        cycle_next = cycle_sum;
        if (cycle_sum >= {1'b0, frame_cycles}) begin
          cycle_next         = '0;
          status_next        = (status_reg & 8'hBF) | 8'h80;
          split_next         = 1'b0;
          poll_next          = '0;
          scroll_x_next      = '0;
          scroll_y_next      = '0;
          scroll_toggle_next = 1'b0;
          hud_x_next         = '0;
          hud_y_next         = '0;
          hud_ctrl_next      = control_reg & pru_pkg::HUD_CTRL_MASK;
          info.nmi           = control_reg[7];
        end
      end
      default: ;
    endcase

    info.split    = split_next;
    info.hud_x    = hud_x_next;
    info.hud_y    = hud_y_next;
    info.hud_ctrl = hud_ctrl_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg   <= '0;
      mask_reg      <= '0;
      status_reg    <= '0;
      sprite_addr   <= '0;
      scroll_x      <= '0;
      scroll_y      <= '0;
      vram_addr     <= '0;
      addr_toggle   <= 1'b0;
      scroll_toggle <= 1'b0;
      split_flag    <= 1'b0;
      poll_count    <= '0;
      hud_x_reg     <= '0;
      hud_y_reg     <= '0;
      hud_ctrl_reg  <= '0;
      cycle_total   <= '0;
    end else if (fire) begin
      control_reg   <= control_next;
      mask_reg      <= mask_next;
      status_reg    <= status_next;
      sprite_addr   <= sprite_addr_next;
      scroll_x      <= scroll_x_next;
      scroll_y      <= scroll_y_next;
      vram_addr     <= vram_addr_next;
      addr_toggle   <= addr_toggle_next;
      scroll_toggle <= scroll_toggle_next;
      split_flag    <= split_next;
      poll_count    <= poll_next;
      hud_x_reg     <= hud_x_next;
      hud_y_reg     <= hud_y_next;
      hud_ctrl_reg  <= hud_ctrl_next;
      cycle_total   <= cycle_next;
    end
  end

endmodule

[sv/picture_unit_register_port.sv]
// top level: stream channels, configuration registers, output stage and read buffer
//
// picture unit cpu register port. each beat on the s_axis side is one bus
// access: a register read, a register write or a cycle tick (kind in tuser).
// every accepted beat gives exactly one result beat on m_axis: the read value,
// the nmi request of a tick that opened vblank, and the captured split state.
// registers are updated as the beat is accepted and the memories are read in
// the same edge; the result appears in the next cycle, and one beat can be
// accepted every cycle while m_axis takes the results.
// the read buffer is advanced when the result beat leaves, keeping order.
// when m_axis stalls the result holds in the output stage; outside the sweep,
// s_axis_tready drops only while a result waits and is not being taken.
// after reset the memories are swept to zero; s_axis_tready
// stays low during the sweep. configuration writes (cfg_*) are taken always,
// and are meant to be issued while no access is in flight.
module picture_unit_register_port #(
  parameter int NAMETABLE_BYTES = 2048,
  parameter int HIT_POLLS       = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // reg_index[2:0], write_data[10:3], tick_cycles[18:11], zero
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], nmi_request[8], split_seen[9], hud_scroll_x[17:10],
  // hud_scroll_y[25:18], hud_control[33:26], zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [2:0]  mirror_mode;
  logic        pattern_is_rom;
  logic [15:0] frame_cycles;

  logic              fire, out_fire, clear_busy, s1_valid;
  pru_pkg::mem_req_t req;
  pru_pkg::s1_info_t info, s1;
  logic [7:0]        spr_q, pal_q, nt_q, pat_q, read_buffer, read_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode    <= 3'd2;
      pattern_is_rom <= 1'b0;
      frame_cycles   <= pru_pkg::RESET_FRAME;
    end else if (cfg_valid) begin
      case (cfg_index)
        pru_pkg::CFG_MIRROR: mirror_mode <= cfg_data[2:0];
        pru_pkg::CFG_ROM:    pattern_is_rom <= cfg_data[0];
        pru_pkg::CFG_FRAME:  frame_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !clear_busy && (!s1_valid || m_axis_tready);
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  pru_regs #(.HIT_POLLS(HIT_POLLS)) u_regs (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .cmd            (s_axis_tuser),
    .reg_index      (s_axis_tdata[2:0]),
    .write_data     (s_axis_tdata[10:3]),
    .tick_cycles    (s_axis_tdata[18:11]),
    .mirror_mode    (mirror_mode),
    .pattern_is_rom (pattern_is_rom),
    .frame_cycles   (frame_cycles),
    .req            (req),
    .info           (info)
  );

  pru_mem #(.NAMETABLE_BYTES(NAMETABLE_BYTES)) u_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (fire),
    .req        (fire ? req : '0),
    .clear_busy (clear_busy),
    .spr_q      (spr_q),
    .pal_q      (pal_q),
    .nt_q       (nt_q),
    .pat_q      (pat_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (m_axis_tready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) s1 <= info;
  end

  // buffered data reads return the old buffer and reload it from memory; address writes clear it
  always_ff @(posedge clk) begin
    if (rst) begin
      read_buffer <= '0;
    end else if (out_fire) begin
      case (s1.kind)
        pru_pkg::RK_PALETTE:  read_buffer <= nt_q;
        pru_pkg::RK_VRAM_NT:  read_buffer <= nt_q;
        pru_pkg::RK_VRAM_PAT: read_buffer <= pat_q;
        pru_pkg::RK_ADDR_CLR: read_buffer <= '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (s1.kind)
      pru_pkg::RK_STATUS:   read_data = s1.value;
      pru_pkg::RK_SPRITE:   read_data = spr_q;
      pru_pkg::RK_PALETTE:  read_data = pal_q;
      pru_pkg::RK_VRAM_NT:  read_data = read_buffer;
      pru_pkg::RK_VRAM_PAT: read_data = read_buffer;
      default:              read_data = '0;
    endcase
  end

  assign m_axis_tvalid = s1_valid;
  assign m_axis_tdata  = {6'd0, s1.hud_ctrl, s1.hud_y, s1.hud_x, s1.split, s1.nmi, read_data};

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !s_axis_tready) else $error("beat accepted during memory sweep");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("beat accepted while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_axis_tvalid) else $error("accepted beat gave no result");

  a_nmi_only_tick: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.nmi) |-> (s1.kind == pru_pkg::RK_NONE))
    else $error("nmi raised on a register access");

endmodule
